FILE: rtl/core/da1_reply_attribute_matcher_assert.svh
// Assertion macros for the DA1 reply attribute matcher.
// Each macro expects clk_i and rst_ni in scope.
`ifndef DA1_REPLY_ATTRIBUTE_MATCHER_ASSERT_SVH
`define DA1_REPLY_ATTRIBUTE_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define DAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DAM_ASSERT_IMP(lbl, ante, cons, msg)
`define DAM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/dam_pkg.sv
package dam_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AttrW = 17;

  localparam logic [AttrW-1:0] ClampLimit = 17'd100000;
  localparam logic [AttrW-1:0] WantedReset = 17'd4;

  localparam logic [ByteW-1:0] ChEsc  = 8'h1b;
  localparam logic [ByteW-1:0] ChLbr  = 8'h5b; // '['
  localparam logic [ByteW-1:0] ChQm   = 8'h3f; // '?'
  localparam logic [ByteW-1:0] ChSemi = 8'h3b; // ';'
  localparam logic [ByteW-1:0] ChC    = 8'h63; // 'c'
  localparam logic [ByteW-1:0] Ch0    = 8'h30;
  localparam logic [ByteW-1:0] Ch9    = 8'h39;

  typedef enum logic [1:0] {
    ST_SEARCH,
    ST_ESC,
    ST_CSI,
    ST_BODY
  } stage_e;

  typedef struct packed {
    logic [ByteW-1:0] reply_byte;
    logic             last_byte;
  } item_t;

endpackage

FILE: rtl/core/dam_in_reg.sv
module dam_in_reg
  import dam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  input  logic [ByteW-1:0] s_data_i,
  input  logic             s_last_i,
  input  logic             adv_i,
  output logic             valid_o,
  output item_t            item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign s_ready_o = !valid_q || adv_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.reply_byte <= s_data_i;
      item_q.last_byte  <= s_last_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/dam_parser.sv
`include "da1_reply_attribute_matcher_assert.svh"

module dam_parser
  import dam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  item_t            item_i,
  input  logic [AttrW-1:0] wanted_i,
  output logic             found_o
);

  stage_e           stage_q, stage_d;
  logic [AttrW-1:0] acc_q, acc_d;
  logic             dig_q, dig_d;
  logic             found_q, found_d;

  logic [ByteW-1:0] b;
  logic             is_digit;
  logic             is_end;
  stage_e           restart;
  logic [AttrW+3:0] acc_x10;

  assign b        = item_i.reply_byte;
  assign is_digit = (b >= Ch0) && (b <= Ch9);
  assign is_end   = (b == ChSemi) || (b == ChC);
  assign restart  = (b == ChEsc) ? ST_ESC : ST_SEARCH;
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {13'd0, b - Ch0};

  // next state
  always_comb begin
    stage_d = stage_q;
    acc_d   = acc_q;
    dig_d   = dig_q;
    found_d = found_q;
    case (stage_q)
      ST_SEARCH: stage_d = restart;
      ST_ESC: begin
        stage_d = (b == ChLbr) ? ST_CSI : restart;
      end
      ST_CSI: begin
        if (b == ChQm) begin
          stage_d = ST_BODY;
          acc_d   = '0;
          dig_d   = 1'b0;
        end else begin
          stage_d = restart;
        end
      end
      ST_BODY: begin
        if (is_digit) begin
          acc_d = (acc_x10 > {4'd0, ClampLimit}) ? ClampLimit : acc_x10[AttrW-1:0];
          dig_d = 1'b1;
        end else if (is_end) begin
          if (dig_q && (acc_q == wanted_i)) begin
            found_d = 1'b1;
          end
          acc_d = '0;
          dig_d = 1'b0;
          if (b == ChC) begin
            stage_d = ST_SEARCH;
          end
        end else begin
          acc_d   = '0;
          dig_d   = 1'b0;
          stage_d = restart;
        end
      end
      default: stage_d = ST_SEARCH;
    endcase
  end

  // outputs
  always_comb begin
    found_o = found_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_SEARCH;
      acc_q   <= '0;
      dig_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (en_i) begin
      if (item_i.last_byte) begin
        stage_q <= ST_SEARCH;
        acc_q   <= '0;
        dig_q   <= 1'b0;
        found_q <= 1'b0;
      end else begin
        stage_q <= stage_d;
        acc_q   <= acc_d;
        dig_q   <= dig_d;
        found_q <= found_d;
      end
    end
  end

  `DAM_ASSERT_IMP(a_acc_clamped, 1'b1, acc_q <= ClampLimit, "accumulator above clamp")
  `DAM_ASSERT_IMP(a_dig_in_body, dig_q, stage_q == ST_BODY, "digits outside body")
  `DAM_ASSERT_IMP(a_acc_has_dig, acc_q != '0, dig_q, "nonzero accumulator without digits")
  `DAM_ASSERT_NXT(a_found_sticky, found_q && !(en_i && item_i.last_byte), found_q,
                  "found flag dropped inside window")

endmodule

FILE: rtl/core/da1_reply_attribute_matcher.sv
// DA1 reply attribute matcher: takes one terminal reply byte per word on the
// slave side and returns one word per byte on the master side, telling
// whether the wanted attribute number has appeared in an ESC [ ? ... c answer
// so far in the current window. A word with tlast closes the window; its
// result is final and the window state clears after it. Throughput is one
// byte per clock while the master side takes results; each result word is
// registered, its byte passing the input register and the parser into the
// result register. A stalled result holds at most one more byte in the input
// register before tready drops. The attribute register resets to 4; the user
// must write it with cfg_we_i only while idle; the block does not enforce it.
`include "da1_reply_attribute_matcher_assert.svh"

module da1_reply_attribute_matcher
  import dam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AttrW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] reply_byte
  input  logic             s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] attribute_found, [7:1] zero
  output logic             m_axis_tlast   // window_done
);

  logic [AttrW-1:0] wanted_q;
  logic             in_valid;
  item_t            in_item;
  logic             out_free;
  logic             adv;
  logic             found;
  logic             m_valid_q, m_valid_d;
  logic             found_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WantedReset;
    end else if (cfg_we_i) begin
      wanted_q <= cfg_wdata_i;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign adv      = in_valid && out_free;

  dam_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_last_i  (s_axis_tlast),
    .adv_i     (adv),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  dam_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .item_i   (in_item),
    .wanted_i (wanted_q),
    .found_o  (found)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (adv) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      found_q <= found;
      done_q  <= in_item.last_byte;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, found_q};
  assign m_axis_tlast  = done_q;

  `DAM_ASSERT_NXT(a_adv_fills_out, adv, m_valid_q, "result word lost")
  `DAM_ASSERT_NXT(a_out_held, m_valid_q && !m_axis_tready, m_valid_q && $stable(found_q),
                  "stalled result changed")
  `DAM_ASSERT_IMP(a_no_adv_blocked, adv, !m_valid_q || m_axis_tready,
                  "advance into occupied result register")

endmodule
